// ----- hdl/scc_pkg.sv -----
// shared constants, types and state codes of the strip cluster centroid unit
package scc_pkg;

  // detector geometry and fixed point format
  localparam int STRIPS        = 1024;
  localparam int PLANES        = 16;
  localparam int FRACTION_BITS = 8;

  // field and accumulator widths
  localparam int PLANE_W  = 4;
  localparam int STRIP_W  = 10;
  localparam int ENERGY_W = 16;
  localparam int ESUM_W   = 26;
  localparam int WSUM_W   = 36;
  localparam int CENT_W   = 18;

  // open cluster as seen by the sequencer and the divider
  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [ESUM_W-1:0]  esum;
    logic [WSUM_W-1:0]  wsum;
  } scc_clu_t;

  // decision for the hit on the input port
  typedef struct packed {
    logic hit_ok;
    logic close_old;
    logic old_done;
  } scc_dec_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_OUT
  } scc_state_e;

endpackage

// ----- hdl/scc_if.sv -----
// hit and cluster result channels with valid/ready handshake
interface scc_hit_if
  import scc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [PLANE_W-1:0]  plane;
  logic [STRIP_W-1:0]  strip;
  logic [ENERGY_W-1:0] energy;
  logic                last_of_plane;

  modport source (output valid, plane, strip, energy, last_of_plane, input ready);
  modport sink   (input valid, plane, strip, energy, last_of_plane, output ready);
endinterface

interface scc_res_if
  import scc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PLANE_W-1:0] out_plane;
  logic [CENT_W-1:0]  centroid;
  logic               zero_energy;
  logic               plane_done;

  modport source (output valid, out_plane, centroid, zero_energy, plane_done, input ready);
  modport sink   (input valid, out_plane, centroid, zero_energy, plane_done, output ready);
endinterface

// ----- hdl/scc_divider.sv -----
// shared restoring divider, one quotient bit per cycle, rounded and saturated
module scc_divider
  import scc_pkg::*;
#(
  parameter int FRAC_BITS = FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ESUM_W-1:0] esum_i,
  input  logic [WSUM_W-1:0] wsum_i,
  output logic              done_o,
  output logic [CENT_W-1:0] cent_o,
  output logic              zero_o
);

  localparam int NW = WSUM_W + FRAC_BITS + 1;
  localparam int CW = $clog2(NW + 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              zero_q, zero_d;
  logic [NW-1:0]     num_q, num_d;
  logic [ESUM_W-1:0] rem_q, rem_d;
  logic [ESUM_W-1:0] den_q, den_d;

  logic [NW-1:0]     num_init;
  logic [ESUM_W:0]   trial;
  logic [ESUM_W:0]   diff;
  logic              ge;

  // numerator with half the divisor added for round half up
  assign num_init = (NW'(wsum_i) << FRAC_BITS) + NW'(esum_i[ESUM_W-1:1]);

  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    zero_d = zero_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      num_d  = num_init;
      rem_d  = '0;
      den_d  = esum_i;
      cnt_d  = CW'(NW);
      zero_d = (esum_i == '0);
      run_d  = (esum_i != '0);
      done_d = (esum_i == '0);
    end else if (run_q) begin
      rem_d = ge ? diff[ESUM_W-1:0] : trial[ESUM_W-1:0];
      num_d = {num_q[NW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign zero_o = zero_q;

  always_comb begin
    if (zero_q) begin
      cent_o = '0;
    end else if (|num_q[NW-1:CENT_W]) begin
      cent_o = '1;
    end else begin
      cent_o = num_q[CENT_W-1:0];
    end
  end

endmodule

// ----- hdl/scc_cluster.sv -----
// open cluster state: run detection and energy / weighted strip accumulation
module scc_cluster
  import scc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                upd_i,
  input  logic [PLANE_W-1:0]  plane_i,
  input  logic [STRIP_W-1:0]  strip_i,
  input  logic [ENERGY_W-1:0] energy_i,
  input  logic                last_i,
  output scc_clu_t            clu_o,
  output scc_dec_t            dec_o
);

  logic [STRIP_W-1:0] prev_q;
  logic               open_q;
  logic [PLANE_W-1:0] plane_q;
  logic [ESUM_W-1:0]  esum_q;
  logic [WSUM_W-1:0]  wsum_q;

  logic [STRIP_W:0]   next_strip;
  logic               adjacent;
  logic               keep;
  logic [ESUM_W-1:0]  prod;

  assign next_strip = {1'b0, prev_q} + (STRIP_W + 1)'(1);
  assign adjacent   = (32'(next_strip) < STRIPS) && ({1'b0, strip_i} == next_strip);

  assign dec_o.hit_ok    = (32'(plane_i) < PLANES) && (32'(strip_i) < STRIPS);
  assign dec_o.old_done  = (plane_i != plane_q);
  assign dec_o.close_old = dec_o.hit_ok && open_q && (dec_o.old_done || !adjacent);

  // keep accumulating only when the open cluster survives this hit
  assign keep = open_q && !dec_o.close_old;
  assign prod = ESUM_W'(energy_i) * ESUM_W'(strip_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      open_q  <= 1'b0;
      plane_q <= '0;
      esum_q  <= '0;
      wsum_q  <= '0;
    end else if (upd_i && dec_o.hit_ok) begin
      prev_q  <= strip_i;
      open_q  <= !last_i;
      plane_q <= plane_i;
      esum_q  <= (keep ? esum_q : '0) + ESUM_W'(energy_i);
      wsum_q  <= (keep ? wsum_q : '0) + WSUM_W'(prod);
    end
  end

  assign clu_o.plane = plane_q;
  assign clu_o.esum  = esum_q;
  assign clu_o.wsum  = wsum_q;

endmodule

// ----- hdl/strip_cluster_centroid_unit.sv -----
// top level: hit intake, close sequencer, shared divider and result register
// sequence: a hit that closes nothing only updates the registered cluster state; a break
//   or plane change hit starts the divider on its accepting edge, a lone last mark via
//   S_START; the 37 + FRACTION_BITS step divider feeds S_OUT and the result register; zero
//   energy skips the steps. throughput: 1 hit/cycle while idle, no hits while a close runs
// reset: rst_ni async low clears cluster state, sequencer and output valid; weighted mode on
module strip_cluster_centroid_unit
  import scc_pkg::*;
#(
  parameter int FRAC_BITS = FRACTION_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  scc_hit_if.sink   hit_i,
  scc_res_if.source res_o
);

  // weighted mode register
  logic wmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wmode_q <= 1'b1;
    end else if (cfg_we_i) begin
      wmode_q <= cfg_data_i;
    end
  end

  // sequencer state
  scc_state_e         state_q, state_d;
  logic               pend_q, pend_d;     // second close (last of plane) still owed
  logic               pdone_q, pdone_d;   // plane_done of the division in flight
  logic [PLANE_W-1:0] dplane_q, dplane_d; // plane of the division in flight

  logic     hit_acc;
  logic     div_start;
  logic     div_done;
  logic     div_zero;
  logic [CENT_W-1:0] div_cent;
  logic     out_load;
  scc_clu_t clu;
  scc_dec_t dec;

  // output register
  logic               ovalid_q;
  logic [PLANE_W-1:0] oplane_q;
  logic [CENT_W-1:0]  ocent_q;
  logic               ozero_q;
  logic               odone_q;

  assign hit_i.ready = (state_q == S_IDLE);
  assign hit_acc     = hit_i.valid && hit_i.ready;

  // cluster tracker updates on every accepted hit, in both modes
  scc_cluster u_cluster (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (hit_acc),
    .plane_i  (hit_i.plane),
    .strip_i  (hit_i.strip),
    .energy_i (hit_i.energy),
    .last_i   (hit_i.last_of_plane),
    .clu_o    (clu),
    .dec_o    (dec)
  );

  // the divider always reads the cluster registers: on the accept edge they still
  // hold the old cluster, in the start state they hold the just closed one
  scc_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .esum_i  (clu.esum),
    .wsum_i  (clu.wsum),
    .done_o  (div_done),
    .cent_o  (div_cent),
    .zero_o  (div_zero)
  );

  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    pdone_d   = pdone_q;
    dplane_d  = dplane_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (hit_acc && dec.hit_ok && wmode_q) begin
          if (dec.close_old) begin
            // old cluster goes first, the hit's own close may follow
            div_start = 1'b1;
            dplane_d  = clu.plane;
            pdone_d   = dec.old_done;
            pend_d    = hit_i.last_of_plane;
            state_d   = S_DIV;
          end else if (hit_i.last_of_plane) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        // close of the cluster ended by last_of_plane
        div_start = 1'b1;
        dplane_d  = clu.plane;
        pdone_d   = 1'b1;
        pend_d    = 1'b0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = pend_q ? S_START : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pdone_q  <= pdone_d;
    dplane_q <= dplane_d;
  end

  // result register, frees the divider while the request waits downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
    end else if (res_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oplane_q <= dplane_q;
      ocent_q  <= div_cent;
      ozero_q  <= div_zero;
      odone_q  <= pdone_q;
    end
  end

  assign res_o.valid       = ovalid_q;
  assign res_o.out_plane   = oplane_q;
  assign res_o.centroid    = ocent_q;
  assign res_o.zero_energy = ozero_q;
  assign res_o.plane_done  = odone_q;

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside of division wait");

  // a pending second close exists only while the sequencer is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q != S_IDLE)
    else $error("pending close with idle sequencer");

  // with weighted mode off an accepted hit never starts a close sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_acc && !wmode_q) |=> state_q == S_IDLE)
    else $error("close sequence started in unweighted mode");

  // a zero energy result carries a zero centroid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ozero_q) |-> ocent_q == '0)
    else $error("nonzero centroid on zero energy cluster");

endmodule

// ----- bench/strip_cluster_centroid_unit_checker.sv -----
// passive checker: predicts cluster centroids from accepted hits and compares results
`timescale 1ns / 100ps
module strip_cluster_centroid_unit_checker
  import scc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_data_i,
  scc_hit_if   hit_i,
  scc_res_if   res_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  localparam logic [CENT_W-1:0] CENT_MAX = '1;

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [CENT_W-1:0]  centroid;
    logic               zero;
    logic               done;
  } cluster_res_t;

  cluster_res_t centroid_q[$];
  cluster_res_t want;

  // predicted cluster state
  logic               weighted_q;
  logic [STRIP_W-1:0] prev_strip;
  logic               open_q;
  logic [ESUM_W-1:0]  esum;
  logic [WSUM_W-1:0]  wsum;
  logic [PLANE_W-1:0] clu_plane;

  function automatic void close_cluster(input logic done);
    cluster_res_t r;
    logic [63:0]  num;
    logic [63:0]  quo;
    open_q = 1'b0;
    if (!weighted_q) return;
    r.plane = clu_plane;
    r.done  = done;
    r.zero  = (esum == '0);
    if (r.zero) begin
      r.centroid = '0;
    end else begin
      // round half up, then clamp to the output range
      num = (64'(wsum) << FRACTION_BITS) + 64'(esum >> 1);
      quo = num / 64'(esum);
      r.centroid = (quo > 64'(CENT_MAX)) ? CENT_MAX : quo[CENT_W-1:0];
    end
    centroid_q = {centroid_q, r};
  endfunction

  function automatic void absorb_hit(input logic [PLANE_W-1:0] plane,
                                     input logic [STRIP_W-1:0] strip,
                                     input logic [ENERGY_W-1:0] energy,
                                     input logic last);
    logic [STRIP_W:0] next;
    if (plane >= PLANES || strip >= STRIPS) return;
    next = {1'b0, prev_strip} + 1'b1;
    if (open_q) begin
      if (plane != clu_plane) close_cluster(1'b1);
      else if (!(next < STRIPS && {1'b0, strip} == next)) close_cluster(1'b0);
    end
    if (!open_q) begin
      open_q    = 1'b1;
      clu_plane = plane;
      esum      = '0;
      wsum      = '0;
    end
    esum       = esum + ESUM_W'(energy);
    wsum       = wsum + WSUM_W'(energy) * WSUM_W'(strip);
    prev_strip = strip;
    if (last) close_cluster(1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weighted_q = 1'b1;
      prev_strip = '0;
      open_q     = 1'b0;
      esum       = '0;
      wsum       = '0;
      clu_plane  = '0;
      centroid_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (centroid_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: unexpected result plane %0d centroid %0d zero %0b done %0b",
                     $time, res_i.out_plane, res_i.centroid, res_i.zero_energy,
                     res_i.plane_done);
        end else begin
          want = centroid_q.pop_front();
          if (res_i.out_plane !== want.plane || res_i.centroid !== want.centroid ||
              res_i.zero_energy !== want.zero || res_i.plane_done !== want.done) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display({"%0t: expected plane %0d centroid %0d zero %0b done %0b,",
                        " got %0d %0d %0b %0b"},
                       $time, want.plane, want.centroid, want.zero, want.done,
                       res_i.out_plane, res_i.centroid, res_i.zero_energy, res_i.plane_done);
          end
        end
      end
      if (hit_i.valid && hit_i.ready)
        absorb_hit(hit_i.plane, hit_i.strip, hit_i.energy, hit_i.last_of_plane);
      if (cfg_we_i) weighted_q = cfg_data_i;
    end
    pending_o = centroid_q.size();
  end

endmodule

// ----- bench/strip_cluster_centroid_unit_tb.sv -----
// top of the strip cluster centroid bench: clock, reset, hit stimulus and verdict
`timescale 1ns / 100ps
module strip_cluster_centroid_unit_tb
  import scc_pkg::*;
;

  // quiet time after the last expected result: one full division and some margin
  localparam int SETTLE_CYCLES  = FRACTION_BITS + 56;
  // cycles without any request moving before the run is declared hung
  localparam int WATCHDOG_LIMIT = 5000;
  // long output hold-off that lets the block back up into its input
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic [PLANE_W-1:0]  plane;
    logic [STRIP_W-1:0]  strip;
    logic [ENERGY_W-1:0] energy;
    logic                last;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;
  int   fail_cnt;
  int   pending;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   hold_left     = 0;
  int   stall_cnt     = 0;

  scc_hit_if hit ();
  scc_res_if res ();

  strip_cluster_centroid_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .hit_i      (hit),
    .res_o      (res)
  );

  strip_cluster_centroid_unit_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .hit_i      (hit),
    .res_i      (res),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, or a counted hold-off when one is requested
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // hang detection: restart the count whenever a request moves on either side
  always @(posedge clk) begin
    if (!rst_n || (hit.valid && hit.ready) || (res.valid && res.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // mostly random energies, with the extremes showing up often
  function automatic logic [ENERGY_W-1:0] pick_energy();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ENERGY_W'($urandom_range(65535));
    endcase
  endfunction

  // offer one hit, with random idle cycles first, and return on its accepting edge
  // valid is left high so back-to-back requests follow without a gap
  task automatic offer_hit(input hit_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      hit.valid <= 1'b0;
      @(posedge clk);
    end
    hit.valid         <= 1'b1;
    hit.plane         <= h.plane;
    hit.strip         <= h.strip;
    hit.energy        <= h.energy;
    hit.last_of_plane <= h.last;
    @(posedge clk);
    while (!hit.ready) @(posedge clk);
  endtask

  // stop offering, let every expected result drain, then let the block go quiet
  task automatic drain_and_settle();
    hit.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_weighted(input logic mode);
    drain_and_settle();
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // one plane worth of sorted hits: a few strip runs split by gaps or repeated
  // strips, usually closed by the last mark, sometimes left open so the next
  // plane has to close it; stray random hits are mixed in as noise
  task automatic send_plane_run(inout int sent);
    hit_t               run_q[$];
    hit_t               h;
    logic [PLANE_W-1:0] pl;
    int                 s;
    int                 n_clu;
    int                 len;
    bit                 zero_clu;
    pl    = PLANE_W'($urandom_range(PLANES - 1));
    // some runs start near the top strip to reach the end of the strip range
    s     = ($urandom_range(3) == 0) ? $urandom_range(STRIPS - 1, STRIPS - 24)
                                     : $urandom_range(900);
    n_clu = $urandom_range(4, 1);
    for (int c = 0; c < n_clu && s < STRIPS; c++) begin
      len      = ($urandom_range(7) == 0) ? $urandom_range(24, 6) : $urandom_range(5, 1);
      zero_clu = ($urandom_range(9) == 0);
      for (int k = 0; k < len && s < STRIPS; k++) begin
        h.plane  = pl;
        h.strip  = STRIP_W'(s);
        h.energy = zero_clu ? '0 : pick_energy();
        h.last   = 1'b0;
        run_q    = {run_q, h};
        s++;
      end
      // repeated strip or a gap, both break the run
      if ($urandom_range(6) == 0) s = s - 1;
      else s = s + $urandom_range(40, 1);
    end
    if ($urandom_range(9) != 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) begin
      if ($urandom_range(14) == 0) begin
        h.plane  = PLANE_W'($urandom_range(PLANES - 1));
        h.strip  = STRIP_W'($urandom_range(STRIPS - 1));
        h.energy = pick_energy();
        h.last   = $urandom_range(1);
        offer_hit(h);
        sent++;
      end
      offer_hit(run_q[i]);
      sent++;
    end
  endtask

  // per phase: sender idle percent, receiver stall percent, weighted mode, hits
  int unsigned idle_tab[5]  = '{0, 60, 0, 37, 0};
  int unsigned stall_tab[5] = '{0, 0, 60, 37, 0};
  bit          mode_tab[5]  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  int          quota_tab[5] = '{250, 120, 250, 230, 250};

  initial begin
    int sent;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = 1'b0;
    hit.valid         = 1'b0;
    hit.plane         = '0;
    hit.strip         = '0;
    hit.energy        = '0;
    hit.last_of_plane = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_weighted(1'b1);

    // directed: field extremes and each corner of the cluster logic
    // run of three closed by the last mark, zero energy in the middle
    offer_hit('{4'd0, 10'd0, 16'hffff, 1'b0});
    offer_hit('{4'd0, 10'd1, 16'h0000, 1'b0});
    offer_hit('{4'd0, 10'd2, 16'h0001, 1'b1});
    // repeated strip, then a gap, both break the run
    offer_hit('{4'd1, 10'd5, 16'd100, 1'b0});
    offer_hit('{4'd1, 10'd5, 16'd200, 1'b0});
    offer_hit('{4'd1, 10'd7, 16'd300, 1'b0});
    // plane change without last mark closes the old plane
    offer_hit('{4'd2, 10'd8, 16'd50, 1'b0});
    // break plus last mark: two results, the second with zero energy
    offer_hit('{4'd2, 10'd20, 16'd0, 1'b1});
    // top strip followed by strip 0 must not count as adjacent
    offer_hit('{4'd3, 10'd1022, 16'd1000, 1'b0});
    offer_hit('{4'd3, 10'd1023, 16'd2000, 1'b0});
    offer_hit('{4'd3, 10'd0, 16'd3000, 1'b0});
    offer_hit('{4'd3, 10'd1, 16'd0, 1'b1});
    // all fields at their maximum, single hit cluster
    offer_hit('{4'd15, 10'd1023, 16'hffff, 1'b1});
    // two hit cluster with zero energy sum
    offer_hit('{4'd4, 10'd10, 16'd0, 1'b0});
    offer_hit('{4'd4, 10'd11, 16'd0, 1'b1});
    // full scale energies over a run of four
    offer_hit('{4'd5, 10'd100, 16'hffff, 1'b0});
    offer_hit('{4'd5, 10'd101, 16'hffff, 1'b0});
    offer_hit('{4'd5, 10'd102, 16'hffff, 1'b0});
    offer_hit('{4'd5, 10'd103, 16'hffff, 1'b1});
    offer_hit('{4'd6, 10'd512, 16'd7, 1'b1});
    // plane change where the strip would otherwise be adjacent
    offer_hit('{4'd15, 10'd0, 16'd1, 1'b0});
    offer_hit('{4'd0, 10'd1, 16'd1, 1'b1});

    // random phases, each entered with the block idle so the mode can change
    for (int ph = 0; ph < 5; ph++) begin
      set_weighted(mode_tab[ph]);
      send_idle_pct = idle_tab[ph];
      stall_pct     = stall_tab[ph];
      if (ph == 4) hold_left = HOLD_CYCLES;
      sent = 0;
      while (sent < quota_tab[ph]) send_plane_run(sent);
    end

    drain_and_settle();
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/scc_pkg.sv
hdl/scc_if.sv
hdl/scc_divider.sv
hdl/scc_cluster.sv
hdl/strip_cluster_centroid_unit.sv
bench/strip_cluster_centroid_unit_checker.sv
bench/strip_cluster_centroid_unit_tb.sv
